@@ hw/rtl/rmv_pkg.sv @@
// constants, types and codes shared by the running mean and variance block
package rmv_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COUNT_BITS     = 16;
	localparam int MEAN_FRAC_BITS = 16;
	localparam int VAR_FRAC_BITS  = 8;
	localparam int TERM_SHIFT     = 2 * MEAN_FRAC_BITS - VAR_FRAC_BITS;
	localparam int SE_SHIFT       = 8;

	localparam int MEAN_W  = SAMPLE_BITS + MEAN_FRAC_BITS;
	localparam int DELTA_W = MEAN_W + 1;
	localparam int WORD_W  = 64;
	localparam int PROD_W  = 2 * WORD_W;
	localparam int VAR_W   = 56;
	localparam int SE_W    = 32;

	localparam int STATUS_W       = 2;
	localparam int SAMPLE_VALUE_W = 24;
	localparam int SAMPLE_COUNT_W = 16;
	localparam int MEAN_VALUE_W   = 40;

	localparam int ALU_ADD_W  = WORD_W + 2;
	localparam int STEP_W     = $clog2(WORD_W + 1);
	localparam int MUL_STEPS  = WORD_W;
	localparam int DIV_STEPS  = WORD_W;
	localparam int SQRT_STEPS = WORD_W / 2;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t SAMPLE_MASK = {{(WORD_W-SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};
	localparam word_t VAR_MAX     = {{(WORD_W-VAR_W){1'b0}}, {VAR_W{1'b1}}};

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		word_t   opa;
		word_t   opb;
	} alu_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEAN,
		S_DELTA2,
		S_PROD,
		S_STATS,
		S_VAR,
		S_SEDIV,
		S_ROOT,
		S_LOAD
	} state_t;

endpackage

@@ hw/rtl/rmv_if.sv @@
// request and result channel interfaces of the running mean and variance block
interface rmv_in_if;
	logic                               valid;
	logic                               ready;
	logic                               command;
	logic [rmv_pkg::SAMPLE_VALUE_W-1:0] sample_value;

	modport source(output valid, command, sample_value, input ready);
	modport sink(input valid, command, sample_value, output ready);
endinterface

interface rmv_out_if;
	logic                               valid;
	logic                               ready;
	logic [rmv_pkg::STATUS_W-1:0]       status;
	logic [rmv_pkg::SAMPLE_COUNT_W-1:0] sample_count;
	logic [rmv_pkg::MEAN_VALUE_W-1:0]   mean_value;
	logic [rmv_pkg::VAR_W-1:0]          sample_variance;
	logic [rmv_pkg::SE_W-1:0]           standard_error;
	logic                               error_valid;

	modport source(output valid, status, sample_count, mean_value, sample_variance,
		standard_error, error_valid, input ready);
	modport sink(input valid, status, sample_count, mean_value, sample_variance,
		standard_error, error_valid, output ready);
endinterface

@@ hw/rtl/rmv_alu.sv @@
// shared bit-serial multiply, divide and square root unit
module rmv_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  rmv_pkg::alu_req_t req,
	output logic              done,
	output rmv_pkg::word_t    res_hi,
	output rmv_pkg::word_t    res_lo
);

	logic                         busy_q;
	logic                         done_q;
	rmv_pkg::alu_op_t             op_q;
	logic [rmv_pkg::STEP_W-1:0]   cnt_q;
	rmv_pkg::word_t               hi_q;
	rmv_pkg::word_t               lo_q;
	rmv_pkg::word_t               arg_q;

	logic [rmv_pkg::ALU_ADD_W-1:0] add_a;
	logic [rmv_pkg::ALU_ADD_W-1:0] add_b;
	logic                          add_sub;
	logic [rmv_pkg::ALU_ADD_W-1:0] add_res;
	logic                          ge;
	rmv_pkg::word_t                rem_sh;
	rmv_pkg::word_t                hi_d;
	rmv_pkg::word_t                lo_d;
	rmv_pkg::word_t                arg_d;

	// one adder shared by every step kind
	assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
	assign ge      = ~add_res[rmv_pkg::ALU_ADD_W-1];

	always_comb begin
		rem_sh  = '0;
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		hi_d    = hi_q;
		lo_d    = lo_q;
		arg_d   = arg_q;
		unique case (op_q)
			rmv_pkg::ALU_MUL: begin
				add_a = {2'b00, hi_q};
				add_b = lo_q[0] ? {2'b00, arg_q} : '0;
				hi_d  = add_res[rmv_pkg::WORD_W:1];
				lo_d  = {add_res[0], lo_q[rmv_pkg::WORD_W-1:1]};
			end
			rmv_pkg::ALU_DIV: begin
				rem_sh  = {hi_q[rmv_pkg::WORD_W-2:0], lo_q[rmv_pkg::WORD_W-1]};
				add_a   = {2'b00, rem_sh};
				add_b   = {2'b00, arg_q};
				add_sub = 1'b1;
				hi_d    = ge ? add_res[rmv_pkg::WORD_W-1:0] : rem_sh;
				lo_d    = {lo_q[rmv_pkg::WORD_W-2:0], ge};
			end
			rmv_pkg::ALU_SQRT: begin
				rem_sh  = {hi_q[rmv_pkg::WORD_W-3:0], lo_q[rmv_pkg::WORD_W-1 -: 2]};
				add_a   = {2'b00, rem_sh};
				add_b   = {2'b00, arg_q[rmv_pkg::WORD_W-3:0], 2'b01};
				add_sub = 1'b1;
				hi_d    = ge ? add_res[rmv_pkg::WORD_W-1:0] : rem_sh;
				lo_d    = {lo_q[rmv_pkg::WORD_W-3:0], 2'b00};
				arg_d   = {arg_q[rmv_pkg::WORD_W-2:0], ge};
			end
			default: begin
				hi_d = hi_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= rmv_pkg::ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				unique case (req.op)
					rmv_pkg::ALU_MUL:  cnt_q <= rmv_pkg::STEP_W'(rmv_pkg::MUL_STEPS);
					rmv_pkg::ALU_DIV:  cnt_q <= rmv_pkg::STEP_W'(rmv_pkg::DIV_STEPS);
					rmv_pkg::ALU_SQRT: cnt_q <= rmv_pkg::STEP_W'(rmv_pkg::SQRT_STEPS);
					default:           cnt_q <= rmv_pkg::STEP_W'(rmv_pkg::DIV_STEPS);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rmv_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q <= '0;
			if (req.op == rmv_pkg::ALU_MUL) begin
				lo_q  <= req.opb;
				arg_q <= req.opa;
			end else if (req.op == rmv_pkg::ALU_DIV) begin
				lo_q  <= req.opa;
				arg_q <= req.opb;
			end else begin
				lo_q  <= req.opa;
				arg_q <= '0;
			end
		end else if (busy_q) begin
			hi_q  <= hi_d;
			lo_q  <= lo_d;
			arg_q <= arg_d;
		end
	end

	assign done   = done_q;
	assign res_hi = hi_q;
	assign res_lo = (op_q == rmv_pkg::ALU_SQRT) ? arg_q : lo_q;

endmodule

@@ hw/rtl/running_mean_variance_top.sv @@
// running mean and variance of a sample stream, welford update on a shared serial unit
//
// channel  dir  payload
// req      in   command, sample_value
// rsp      out  status, sample_count, mean_value, sample_variance, standard_error,
//               error_valid
//
// an added sample with two or more samples runs divide, multiply, divide, divide and
// root on the shared unit, which retires one bit per cycle; a clear runs no unit step,
// a full-count reject runs divide, divide and root, a first sample divide and multiply
// req.ready is high only between requests; a result waits in the output register
// and the next request is taken meanwhile; reset zeroes count, mean and deviation sum
module running_mean_variance_top (
	input logic          clk,
	input logic          arst_n,
	rmv_in_if.sink       req,
	rmv_out_if.source    rsp
);

	rmv_pkg::state_t  state_q;
	rmv_pkg::state_t  state_d;
	rmv_pkg::alu_req_t alu_req;
	logic             alu_done;
	rmv_pkg::word_t   alu_hi;
	rmv_pkg::word_t   alu_lo;

	logic [rmv_pkg::COUNT_BITS-1:0] count_q;
	logic [rmv_pkg::MEAN_W-1:0]     mean_q;
	rmv_pkg::word_t                 dev_q;
	rmv_pkg::status_t               status_q;
	logic [rmv_pkg::MEAN_W-1:0]     xq_q;
	logic                           dneg_q;
	logic [rmv_pkg::MEAN_W-1:0]     dmag_q;
	logic [rmv_pkg::MEAN_W-1:0]     nmean_q;
	logic                           pneg_q;
	logic [rmv_pkg::VAR_W-1:0]      var_q;
	logic [rmv_pkg::SE_W-1:0]       se_q;

	logic                                ov_q;
	rmv_pkg::status_t                    o_status_q;
	logic [rmv_pkg::SAMPLE_COUNT_W-1:0]  o_count_q;
	logic [rmv_pkg::MEAN_VALUE_W-1:0]    o_mean_q;
	logic [rmv_pkg::VAR_W-1:0]           o_var_q;
	logic [rmv_pkg::SE_W-1:0]            o_se_q;
	logic                                o_evalid_q;

	logic                           accept;
	logic                           count_full;
	logic                           two_plus;
	rmv_pkg::word_t                 x_in;
	logic [rmv_pkg::MEAN_W-1:0]     xq_in;
	logic [rmv_pkg::DELTA_W-1:0]    delta_in;
	logic [rmv_pkg::DELTA_W-1:0]    dmag_in;
	logic [rmv_pkg::COUNT_BITS-1:0] n_in;
	logic [rmv_pkg::MEAN_W-1:0]     quo;
	logic [rmv_pkg::DELTA_W-1:0]    delta2;
	logic [rmv_pkg::DELTA_W-1:0]    d2mag;
	logic [rmv_pkg::PROD_W-1:0]     term_full;
	logic                           term_hi_nz;
	rmv_pkg::word_t                 mag;
	logic [rmv_pkg::WORD_W:0]       dev_sub;
	logic [rmv_pkg::WORD_W:0]       dev_add;
	logic                           sub_le;
	rmv_pkg::word_t                 var_sat;
	logic                           load_out;

	rmv_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.done   (alu_done),
		.res_hi (alu_hi),
		.res_lo (alu_lo)
	);

	assign accept     = req.valid & req.ready;
	assign count_full = &count_q;
	assign two_plus   = count_q >= rmv_pkg::COUNT_BITS'(2);

	// request side
	assign x_in     = rmv_pkg::WORD_W'(req.sample_value) & rmv_pkg::SAMPLE_MASK;
	assign xq_in    = {x_in[rmv_pkg::SAMPLE_BITS-1:0], {rmv_pkg::MEAN_FRAC_BITS{1'b0}}};
	assign delta_in = {1'b0, xq_in} - {1'b0, mean_q};
	assign dmag_in  = delta_in[rmv_pkg::DELTA_W-1] ? (~delta_in + 1'b1) : delta_in;
	assign n_in     = count_q + 1'b1;

	// mean step and second deviation
	assign quo    = alu_lo[rmv_pkg::MEAN_W-1:0];
	assign delta2 = {1'b0, xq_q} - {1'b0, nmean_q};
	assign d2mag  = delta2[rmv_pkg::DELTA_W-1] ? (~delta2 + 1'b1) : delta2;

	// deviation sum update
	assign term_full  = {alu_hi, alu_lo} >> rmv_pkg::TERM_SHIFT;
	assign term_hi_nz = |term_full[rmv_pkg::PROD_W-1:rmv_pkg::WORD_W];
	assign mag        = term_full[rmv_pkg::WORD_W-1:0];
	assign dev_sub    = {1'b0, dev_q} - {1'b0, mag};
	assign dev_add    = {1'b0, dev_q} + {1'b0, mag};
	assign sub_le     = dev_sub[rmv_pkg::WORD_W] | (dev_sub[rmv_pkg::WORD_W-1:0] == '0);

	assign var_sat  = (alu_lo > rmv_pkg::VAR_MAX) ? rmv_pkg::VAR_MAX : alu_lo;
	assign load_out = (state_q == rmv_pkg::S_LOAD) && (!ov_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmv_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		alu_req     = '0;
		alu_req.op  = rmv_pkg::ALU_DIV;
		req.ready   = 1'b0;
		unique case (state_q)
			rmv_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.command == rmv_pkg::CMD_CLEAR || count_full) begin
						state_d = rmv_pkg::S_STATS;
					end else begin
						alu_req.start = 1'b1;
						alu_req.op    = rmv_pkg::ALU_DIV;
						alu_req.opa   = rmv_pkg::WORD_W'(dmag_in);
						alu_req.opb   = rmv_pkg::WORD_W'(n_in);
						state_d       = rmv_pkg::S_MEAN;
					end
				end
			end
			rmv_pkg::S_MEAN: begin
				if (alu_done) begin
					state_d = rmv_pkg::S_DELTA2;
				end
			end
			rmv_pkg::S_DELTA2: begin
				alu_req.start = 1'b1;
				alu_req.op    = rmv_pkg::ALU_MUL;
				alu_req.opa   = rmv_pkg::WORD_W'(dmag_q);
				alu_req.opb   = rmv_pkg::WORD_W'(d2mag);
				state_d       = rmv_pkg::S_PROD;
			end
			rmv_pkg::S_PROD: begin
				if (alu_done) begin
					state_d = rmv_pkg::S_STATS;
				end
			end
			rmv_pkg::S_STATS: begin
				if (two_plus) begin
					alu_req.start = 1'b1;
					alu_req.op    = rmv_pkg::ALU_DIV;
					alu_req.opa   = dev_q;
					alu_req.opb   = rmv_pkg::WORD_W'(count_q - 1'b1);
					state_d       = rmv_pkg::S_VAR;
				end else begin
					state_d = rmv_pkg::S_LOAD;
				end
			end
			rmv_pkg::S_VAR: begin
				if (alu_done) begin
					alu_req.start = 1'b1;
					alu_req.op    = rmv_pkg::ALU_DIV;
					alu_req.opa   = var_sat;
					alu_req.opb   = rmv_pkg::WORD_W'(count_q);
					state_d       = rmv_pkg::S_SEDIV;
				end
			end
			rmv_pkg::S_SEDIV: begin
				if (alu_done) begin
					alu_req.start = 1'b1;
					alu_req.op    = rmv_pkg::ALU_SQRT;
					alu_req.opa   = alu_lo << rmv_pkg::SE_SHIFT;
					state_d       = rmv_pkg::S_ROOT;
				end
			end
			rmv_pkg::S_ROOT: begin
				if (alu_done) begin
					state_d = rmv_pkg::S_LOAD;
				end
			end
			rmv_pkg::S_LOAD: begin
				if (load_out) begin
					state_d = rmv_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rmv_pkg::S_IDLE;
			end
		endcase
	end

	// statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mean_q   <= '0;
			dev_q    <= '0;
			status_q <= rmv_pkg::STATUS_OK;
		end else begin
			if (accept) begin
				if (req.command == rmv_pkg::CMD_CLEAR) begin
					count_q  <= '0;
					mean_q   <= '0;
					dev_q    <= '0;
					status_q <= rmv_pkg::STATUS_OK;
				end else if (count_full) begin
					status_q <= rmv_pkg::STATUS_FULL;
				end else begin
					status_q <= rmv_pkg::STATUS_OK;
				end
			end else if (state_q == rmv_pkg::S_PROD && alu_done) begin
				if (pneg_q && mag != '0) begin
					count_q <= count_q + 1'b1;
					mean_q  <= nmean_q;
					dev_q   <= (term_hi_nz || sub_le) ? '0 : dev_sub[rmv_pkg::WORD_W-1:0];
				end else if (term_hi_nz || dev_add[rmv_pkg::WORD_W]) begin
					status_q <= rmv_pkg::STATUS_OVERFLOW;
				end else begin
					count_q <= count_q + 1'b1;
					mean_q  <= nmean_q;
					dev_q   <= dev_add[rmv_pkg::WORD_W-1:0];
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			xq_q   <= xq_in;
			dneg_q <= delta_in[rmv_pkg::DELTA_W-1];
			dmag_q <= dmag_in[rmv_pkg::MEAN_W-1:0];
		end
		if (state_q == rmv_pkg::S_MEAN && alu_done) begin
			nmean_q <= dneg_q ? (mean_q - quo) : (mean_q + quo);
		end
		if (state_q == rmv_pkg::S_DELTA2) begin
			pneg_q <= dneg_q ^ delta2[rmv_pkg::DELTA_W-1];
		end
		if (state_q == rmv_pkg::S_STATS && !two_plus) begin
			var_q <= '0;
			se_q  <= '0;
		end
		if (state_q == rmv_pkg::S_VAR && alu_done) begin
			var_q <= var_sat[rmv_pkg::VAR_W-1:0];
		end
		if (state_q == rmv_pkg::S_ROOT && alu_done) begin
			se_q <= alu_lo[rmv_pkg::SE_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_out) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_status_q <= status_q;
			o_count_q  <= (rmv_pkg::SAMPLE_COUNT_W)'(count_q);
			o_mean_q   <= (rmv_pkg::MEAN_VALUE_W)'(mean_q);
			o_var_q    <= var_q;
			o_se_q     <= se_q;
			o_evalid_q <= two_plus;
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.status          = o_status_q;
	assign rsp.sample_count    = o_count_q;
	assign rsp.mean_value      = o_mean_q;
	assign rsp.sample_variance = o_var_q;
	assign rsp.standard_error  = o_se_q;
	assign rsp.error_valid     = o_evalid_q;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == rmv_pkg::CMD_CLEAR) |=>
		(count_q == '0 && mean_q == '0 && dev_q == '0))
		else $error("clear did not zero the statistics");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == '0 || count_q == $past(count_q) + 1'b1))
		else $error("sample count moved by more than one");

	a_error_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.error_valid) |->
		(rsp.sample_count >= rmv_pkg::SAMPLE_COUNT_W'(2)))
		else $error("error flagged valid below two samples");

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == rmv_pkg::S_MEAN || state_q == rmv_pkg::S_PROD ||
		state_q == rmv_pkg::S_VAR || state_q == rmv_pkg::S_SEDIV ||
		state_q == rmv_pkg::S_ROOT))
		else $error("shared unit finished outside a wait state");

endmodule
